### rtl/scbp_pkg.sv
// Shared types and constants for the serial command byte parser.
package scbp_pkg;

   // ASCII codes of the command letters and digits
   localparam logic [7:0] ASCII_ZERO   = 8'd48;
   localparam logic [7:0] ASCII_NINE   = 8'd57;
   localparam logic [7:0] CHAR_T_UPPER = 8'h54;
   localparam logic [7:0] CHAR_T_LOWER = 8'h74;
   localparam logic [7:0] CHAR_C_UPPER = 8'h43;
   localparam logic [7:0] CHAR_C_LOWER = 8'h63;
   localparam logic [7:0] CHAR_R_UPPER = 8'h52;
   localparam logic [7:0] CHAR_R_LOWER = 8'h72;
   localparam logic [7:0] CHAR_A_UPPER = 8'h41;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;
   localparam logic [7:0] CHAR_B_UPPER = 8'h42;
   localparam logic [7:0] CHAR_B_LOWER = 8'h62;

   // Command codes from the byte decoder
   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_THERMO = 3'd1;
   localparam logic [2:0] CMD_HEAT   = 3'd2;
   localparam logic [2:0] CMD_COOL   = 3'd3;
   localparam logic [2:0] CMD_LOWER  = 3'd4;
   localparam logic [2:0] CMD_UPPER  = 3'd5;

   // Mode codes
   localparam logic [1:0] MODE_THERMO = 2'd0;
   localparam logic [1:0] MODE_HEAT   = 2'd1;
   localparam logic [1:0] MODE_COOL   = 2'd2;

   // Parse phase codes
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_LO_TENS  = 3'd1;
   localparam logic [2:0] PH_HI_TENS  = 3'd2;
   localparam logic [2:0] PH_LO_UNITS = 3'd3;
   localparam logic [2:0] PH_HI_UNITS = 3'd4;

   localparam logic [6:0] UPPER_RESET = 7'd99;

   typedef struct packed {
      logic       is_digit;
      logic [3:0] digit;
      logic [2:0] cmd;
   } decode_type;

   typedef struct packed {
      logic [1:0] mode_now;
      logic [6:0] lower_limit;
      logic [6:0] upper_limit;
      logic [2:0] parse_phase;
   } result_type;

endpackage

### rtl/scbp_decode.sv
// Byte classifier: digit value and command letter of one received byte.
module scbp_decode (
   input  logic [7:0]               rx_byte,
   output scbp_pkg::decode_type     dec
);
   import scbp_pkg::*;

   logic [7:0] offset;

   assign offset = rx_byte - ASCII_ZERO;

   // digit test and value, then map command letters, either case
   always_comb begin
      dec.is_digit = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
      dec.digit    = offset[3:0];
      case (rx_byte)
         CHAR_T_UPPER, CHAR_T_LOWER: dec.cmd = CMD_THERMO;
         CHAR_C_UPPER, CHAR_C_LOWER: dec.cmd = CMD_HEAT;
         CHAR_R_UPPER, CHAR_R_LOWER: dec.cmd = CMD_COOL;
         CHAR_B_UPPER, CHAR_B_LOWER: dec.cmd = CMD_LOWER;
         CHAR_A_UPPER, CHAR_A_LOWER: dec.cmd = CMD_UPPER;
         default:                    dec.cmd = CMD_NONE;
      endcase
   end

endmodule

### rtl/scbp_rsp_buf.sv
// Result register with a skid stage so one further request is taken while the receiver stalls.
module scbp_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  scbp_pkg::result_type  in_data,
   output logic                  in_stall,
   output logic                  out_valid,
   output scbp_pkg::result_type  out_data,
   input  logic                  out_stall
);
   import scbp_pkg::*;

   logic       out_vld_ff, out_vld_in;
   logic       skid_vld_ff, skid_vld_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       accept;
   logic       out_free;

   assign in_stall  = skid_vld_ff;
   assign accept    = in_valid && !skid_vld_ff;
   assign out_free  = !out_vld_ff || !out_stall;
   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;

   // refill the output from the skid first, else from a new request
   always_comb begin
      out_vld_in   = out_vld_ff;
      skid_vld_in  = skid_vld_ff;
      out_data_in  = out_data_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = accept;
            out_data_in = in_data;
         end
      end else if (accept) begin
         skid_vld_in  = 1'b1;
         skid_data_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

### rtl/serial_command_byte_parser.sv
// Top level of the serial command byte parser: parse state and result path.
//
// One request carries one received byte on req_rx_byte. Mode letters T, C and R
// (either case) select thermometer, heating or cooling; B and A start a two-digit
// decimal entry of the lower or upper limit, tens digit first. A finished limit
// is kept only if the lower limit stays below the upper one.
// Every request gives exactly one response with the mode, both limits and the
// parse phase as they stand after that byte.
// The response is registered in the output stage, or in the skid stage while held.
// Throughput: one request per cycle while req_stall is low; the next parse state
// comes combinationally from decode, add and compare, so bytes may arrive back to back.
// When rsp_stall is held, one further request is taken into a skid stage and
// req_stall then rises until the receiver takes the waiting response.
// Reset (synchronous, active high) returns the parser to idle, thermometer mode,
// lower limit 0 and upper limit 99, and empties the response path.
module serial_command_byte_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_mode_now,
   output logic [6:0] rsp_lower_limit,
   output logic [6:0] rsp_upper_limit,
   output logic [2:0] rsp_parse_phase
);
   import scbp_pkg::*;

   decode_type dec;
   result_type res_next;
   result_type res_out;
   logic       accept;
   logic [6:0] tens_val;
   logic [6:0] entry_val;

   logic [2:0] phase_ff, phase_in;
   logic [6:0] partial_ff, partial_in;
   logic [1:0] mode_ff, mode_in;
   logic [6:0] lower_ff, lower_in;
   logic [6:0] upper_ff, upper_in;

   scbp_decode u_decode (
      .rx_byte (req_rx_byte),
      .dec     (dec)
   );

   assign accept = req_valid && !req_stall;

   // tens value as 8d + 2d, finished value as tens plus units
   assign tens_val  = {dec.digit, 3'b000} + {2'b00, dec.digit, 1'b0};
   assign entry_val = partial_ff + {3'b000, dec.digit};

   // advance the parse state for the accepted byte
   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      mode_in    = mode_ff;
      lower_in   = lower_ff;
      upper_in   = upper_ff;
      if (accept) begin
         case (phase_ff)
            PH_LO_TENS, PH_HI_TENS: begin
               if (dec.is_digit) begin
                  partial_in = tens_val;
                  phase_in   = (phase_ff == PH_LO_TENS) ? PH_LO_UNITS : PH_HI_UNITS;
               end
            end
            PH_LO_UNITS: begin
               if (dec.is_digit) begin
                  if (entry_val < upper_ff) lower_in = entry_val;
                  phase_in = PH_IDLE;
               end
            end
            PH_HI_UNITS: begin
               if (dec.is_digit) begin
                  if (entry_val > lower_ff) upper_in = entry_val;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               case (dec.cmd)
                  CMD_THERMO: mode_in  = MODE_THERMO;
                  CMD_HEAT:   mode_in  = MODE_HEAT;
                  CMD_COOL:   mode_in  = MODE_COOL;
                  CMD_LOWER:  phase_in = PH_LO_TENS;
                  CMD_UPPER:  phase_in = PH_HI_TENS;
                  default:    ;
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         partial_ff <= 7'd0;
         mode_ff    <= MODE_THERMO;
         lower_ff   <= 7'd0;
         upper_ff   <= UPPER_RESET;
      end else begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
         mode_ff    <= mode_in;
         lower_ff   <= lower_in;
         upper_ff   <= upper_in;
      end
   end

   // pack the state after this byte as the response
   assign res_next.mode_now    = mode_in;
   assign res_next.lower_limit = lower_in;
   assign res_next.upper_limit = upper_in;
   assign res_next.parse_phase = phase_in;

   scbp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (res_next),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (res_out),
      .out_stall (rsp_stall)
   );

   assign rsp_mode_now    = res_out.mode_now;
   assign rsp_lower_limit = res_out.lower_limit;
   assign rsp_upper_limit = res_out.upper_limit;
   assign rsp_parse_phase = res_out.parse_phase;

endmodule
